### design/vtcu_pkg.sv
// ----------------------------------------------------------------------------
// vtcu_pkg: shared definitions of the versioned transaction commit unit
// sizes, request and status codes, controller to datapath command types
// ----------------------------------------------------------------------------
package vtcu_pkg;

  localparam int ADDR_BITS    = 10;
  localparam int NUM_CONTEXTS = 4;
  localparam int SET_DEPTH    = 8;

  localparam int CELL_COUNT = 1 << ADDR_BITS;
  localparam int ENT_COUNT  = NUM_CONTEXTS * SET_DEPTH;
  localparam int ENT_BITS   = (ENT_COUNT > 1) ? $clog2(ENT_COUNT) : 1;
  localparam int SLOT_BITS  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(SET_DEPTH + 1);

  // request operations
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_COMMIT  = 3'd3;
  localparam logic [2:0] OP_DISCARD = 3'd4;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_INIT = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_SCAN_W,
    CMD_SCAN_R,
    CMD_CELL_RD,
    CMD_CHK,
    CMD_CMT,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SLOT_BITS-1:0]   slot;
    logic                   issue;  // slot is looked up this cycle
    logic                   drain;  // previous slot's cell data is ready
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] version;
    logic [31:0] content;
  } cell_t;

endpackage

### design/versioned_tx_commit_unit.sv
// ----------------------------------------------------------------------------
// versioned_tx_commit_unit: versioned cell store with transaction contexts
// optimistic read/write sets, validated and applied on commit
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown on read_value and status for one cycle with done
// high; the receiver cannot hold it off. Requests are processed one at a
// time. After reset the unit sweeps the cell store once, one cell per cycle,
// and keeps busy high during that sweep. Request phases: init does a cell
// lookup then finish; read does a write-set scan, read-set scan, cell lookup
// and finish; write does a write-set scan then finish; commit does validation
// of the read set then write-back of the write set, one entry per cycle
// through the single cell store read port, then finish; discard and ignored
// requests go straight to finish. Busy drops in the cycle the result is shown,
// so the next request can be taken right away.
// ----------------------------------------------------------------------------
module versioned_tx_commit_unit
  import vtcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic [1:0]         context_id,
  input  logic [9:0]         location,
  input  logic signed [31:0] write_value,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [1:0]         status
);

  // controller to datapath commands and status
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks set slots with a shared counter
  vtcu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .context_id (context_id),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  // cell store, read/write sets and result registers
  vtcu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .context_id  (context_id),
    .location    (location),
    .write_value (write_value),
    .stat        (stat),
    .done        (done),
    .read_value  (read_value),
    .status      (status)
  );

endmodule

### design/vtcu_ctrl.sv
// ----------------------------------------------------------------------------
// vtcu_ctrl: request sequencer
// walks each request through its own subset of the scan, lookup, check and commit phases
// ----------------------------------------------------------------------------
module vtcu_ctrl
  import vtcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  operation,
  input  logic [1:0]  context_id,
  input  dp_stat_t    stat,
  output logic        busy,
  output dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_W,
    S_SCAN_R,
    S_CELL_RD,
    S_CHK,
    S_CMT,
    S_FINISH
  } state_t;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SET_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(SET_DEPTH);

  state_t              state;
  logic [CNT_BITS-1:0] cnt;
  logic [2:0]          op_r;
  logic                ctx_ok;

  assign ctx_ok = int'(context_id) < NUM_CONTEXTS;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      op_r  <= OP_INIT;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r <= operation;
            cnt  <= '0;
            if (operation == OP_INIT) state <= S_CELL_RD;
            else if (ctx_ok && (operation == OP_READ || operation == OP_WRITE))
              state <= S_SCAN_W;
            else if (ctx_ok && operation == OP_COMMIT) state <= S_CHK;
            else state <= S_FINISH;
          end
        end
        S_SCAN_W: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= (op_r == OP_READ) ? S_SCAN_R : S_FINISH;
          end else cnt <= cnt + 1'b1;
        end
        S_SCAN_R: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= S_CELL_RD;
          end else cnt <= cnt + 1'b1;
        end
        S_CELL_RD: state <= S_FINISH;
        S_CHK: begin
          if (cnt == CNT_FULL) begin
            cnt   <= '0;
            state <= S_CMT;
          end else cnt <= cnt + 1'b1;
        end
        S_CMT: begin
          if (cnt == CNT_FULL) begin
            cnt   <= '0;
            state <= S_FINISH;
          end else cnt <= cnt + 1'b1;
        end
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.slot  = cnt[SLOT_BITS-1:0];
    cmd.issue = (cnt != CNT_FULL);
    cmd.drain = (cnt != '0);
    case (state)
      S_CLEAR:   cmd.kind = CMD_CLEAR;
      S_IDLE:    cmd.kind = start ? CMD_LOAD : CMD_NONE;
      S_SCAN_W:  cmd.kind = CMD_SCAN_W;
      S_SCAN_R:  cmd.kind = CMD_SCAN_R;
      S_CELL_RD: cmd.kind = CMD_CELL_RD;
      S_CHK:     cmd.kind = CMD_CHK;
      S_CMT:     cmd.kind = CMD_CMT;
      S_FINISH:  cmd.kind = CMD_FINISH;
      default:   cmd.kind = CMD_NONE;
    endcase
  end

  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (state == S_IDLE))
    else $error("finish did not return to idle");

  a_check_then_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && cnt == CNT_FULL) |=> (state == S_CMT && cnt == '0))
    else $error("check phase did not hand over to commit phase");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("slot counter overran the set depth");

endmodule

### design/vtcu_dp.sv
// ----------------------------------------------------------------------------
// vtcu_dp: datapath of the commit unit
// cell store, per-context read and write sets, result registers
// ----------------------------------------------------------------------------
module vtcu_dp
  import vtcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [2:0]         operation,
  input  logic [1:0]         context_id,
  input  logic [9:0]         location,
  input  logic signed [31:0] write_value,
  output dp_stat_t           stat,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [1:0]         status
);

  // cell store
  cell_t                 cell_mem [CELL_COUNT];
  cell_t                 cell_q;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  cell_t                 wr_data;
  logic [ADDR_BITS-1:0]  clr_addr;

  // read and write sets
  logic [ENT_COUNT-1:0]  rvalid;
  logic [ENT_COUNT-1:0]  wvalid;
  logic [ADDR_BITS-1:0]  rloc [ENT_COUNT];
  logic [31:0]           rver [ENT_COUNT];
  logic [ADDR_BITS-1:0]  wloc [ENT_COUNT];
  logic [31:0]           wval [ENT_COUNT];

  // latched request
  logic [2:0]            req_op;
  logic [1:0]            req_ctx;
  logic                  req_ctx_ok;
  logic [ADDR_BITS-1:0]  req_loc;
  logic [31:0]           req_val;

  // scan results
  logic                  w_hit, w_free, r_hit, r_free;
  logic [SLOT_BITS-1:0]  w_hit_slot, w_free_slot, r_hit_slot, r_free_slot;

  // check and commit pipeline
  logic                  chk_pend;
  logic [31:0]           chk_ver;
  logic                  conflict;
  logic                  cmt_pend;
  logic [ADDR_BITS-1:0]  cmt_addr;
  logic [31:0]           cmt_val;

  logic [SLOT_BITS-1:0]  fin_slot;
  logic [SLOT_BITS-1:0]  slot_sel;
  logic [ENT_BITS-1:0]   ent;
  logic                  rd_ok;

  // result of the request in its finish cycle
  logic signed [31:0]    read_value_next;
  logic [1:0]            status_next;

  assign stat.clear_last = (clr_addr == '1);

  always_comb begin
    if (req_op == OP_READ)
      fin_slot = w_hit ? w_hit_slot : (r_hit ? r_hit_slot : r_free_slot);
    else
      fin_slot = w_hit ? w_hit_slot : w_free_slot;
    slot_sel = (cmd.kind == CMD_FINISH) ? fin_slot : cmd.slot;
    ent      = ENT_BITS'(int'(req_ctx) * SET_DEPTH + int'(slot_sel));
  end

  // cell read ok if valid, unshadowed by a buffered write, read set has room
  assign rd_ok = !w_hit && cell_q.valid && (r_hit || r_free);

  always_comb begin
    read_value_next = '0;
    status_next     = ST_OK;
    if (req_ctx_ok) begin
      case (req_op)
        OP_READ: begin
          if (w_hit) read_value_next = $signed(wval[ent]);
          else if (!cell_q.valid) status_next = ST_NOT_INIT;
          else if (r_hit || r_free) read_value_next = $signed(cell_q.content);
          else status_next = ST_FULL;
        end
        OP_WRITE:  if (!(w_hit || w_free)) status_next = ST_FULL;
        OP_COMMIT: if (conflict) status_next = ST_CONFLICT;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.kind)
      CMD_CHK: rd_addr = rloc[ent];
      CMD_CMT: rd_addr = wloc[ent];
      default: rd_addr = req_loc;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_loc;
    wr_data = '0;
    case (cmd.kind)
      CMD_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      CMD_FINISH: begin
        if (req_op == OP_INIT && !cell_q.valid) begin
          wr_en   = 1'b1;
          wr_data = '{valid: 1'b1, version: 32'd0, content: req_val};
        end
      end
      CMD_CMT: begin
        if (cmd.drain && cmt_pend && !conflict) begin
          wr_en   = 1'b1;
          wr_addr = cmt_addr;
          wr_data = '{valid: 1'b1,
                      version: cell_q.valid ? cell_q.version + 32'd1 : 32'd0,
                      content: cmt_val};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) cell_mem[wr_addr] <= wr_data;
    cell_q <= cell_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      rvalid   <= '0;
      wvalid   <= '0;
      clr_addr <= '0;
    end else begin
      done <= (cmd.kind == CMD_FINISH);
      case (cmd.kind)
        CMD_CLEAR: clr_addr <= clr_addr + 1'b1;
        CMD_FINISH: begin
          if (req_ctx_ok) begin
            case (req_op)
              OP_READ:  if (rd_ok) rvalid[ent] <= 1'b1;
              OP_WRITE: if (w_hit || w_free) wvalid[ent] <= 1'b1;
              OP_COMMIT, OP_DISCARD: begin
                for (int s = 0; s < SET_DEPTH; s++) begin
                  rvalid[ENT_BITS'(int'(req_ctx) * SET_DEPTH + s)] <= 1'b0;
                  wvalid[ENT_BITS'(int'(req_ctx) * SET_DEPTH + s)] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.kind)
      CMD_LOAD: begin
        req_op     <= operation;
        req_ctx    <= context_id;
        req_ctx_ok <= int'(context_id) < NUM_CONTEXTS;
        req_loc    <= ADDR_BITS'(location);
        req_val    <= write_value;
        w_hit      <= 1'b0;
        w_free     <= 1'b0;
        r_hit      <= 1'b0;
        r_free     <= 1'b0;
        conflict   <= 1'b0;
      end
      CMD_SCAN_W: begin
        if (!w_hit && wvalid[ent] && wloc[ent] == req_loc) begin
          w_hit      <= 1'b1;
          w_hit_slot <= cmd.slot;
        end
        if (!w_free && !wvalid[ent]) begin
          w_free      <= 1'b1;
          w_free_slot <= cmd.slot;
        end
      end
      CMD_SCAN_R: begin
        if (!r_hit && rvalid[ent] && rloc[ent] == req_loc) begin
          r_hit      <= 1'b1;
          r_hit_slot <= cmd.slot;
        end
        if (!r_free && !rvalid[ent]) begin
          r_free      <= 1'b1;
          r_free_slot <= cmd.slot;
        end
      end
      CMD_CHK: begin
        if (cmd.issue) begin
          chk_pend <= rvalid[ent];
          chk_ver  <= rver[ent];
        end
        if (cmd.drain && chk_pend &&
            (!cell_q.valid || cell_q.version != chk_ver))
          conflict <= 1'b1;
      end
      CMD_CMT: begin
        if (cmd.issue) begin
          cmt_pend <= wvalid[ent];
          cmt_addr <= wloc[ent];
          cmt_val  <= wval[ent];
        end
      end
      CMD_FINISH: begin
        read_value <= read_value_next;
        status     <= status_next;
        if (req_ctx_ok && req_op == OP_READ && rd_ok) begin
          rloc[ent] <= req_loc;
          rver[ent] <= cell_q.version;
        end
        if (req_ctx_ok && req_op == OP_WRITE && (w_hit || w_free)) begin
          wloc[ent] <= req_loc;
          wval[ent] <= req_val;
        end
      end
      default: ;
    endcase
  end

endmodule
